/* hw/rtl/sor_pkg.sv */
// Shared constants and types for the strided offset remap unit.
// Used by sor_div_slice and strided_offset_remap_unit; depends on nothing.

package sor_pkg;

   // Offset and stride geometry
   localparam int OFFSET_BITS = 16;
   localparam int MAX_RANK    = 4;
   localparam int PACKED_DIMS = 4;
   localparam int STRIDE_BITS = 16;
   localparam int CFG_BITS    = 64;
   localparam int RANK_BITS   = 3;
   localparam int RDIM_BITS   = 2;
   localparam int CSR_IDX_BITS = 3;

   localparam int USED_DIMS = (MAX_RANK < PACKED_DIMS) ? MAX_RANK : PACKED_DIMS;

   // Division: a few restoring steps per stage, dividend padded to whole stages
   localparam int STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES = (OFFSET_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int DVD_BITS   = DIV_STAGES * STEPS_PER_STAGE;
   localparam int PROD_BITS  = OFFSET_BITS + STRIDE_BITS;

   // Input stage, division stages for every dimension, multiply, accumulate
   localparam int LAST_DIV   = USED_DIMS * DIV_STAGES;
   localparam int NUM_STAGES = LAST_DIV + 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RANK        = 3'd0,
      CSR_SRC_STRIDES = 3'd1,
      CSR_DST_STRIDES = 3'd2,
      CSR_REDUCE_EN   = 3'd3,
      CSR_REDUCE_DIM  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [STRIDE_BITS-1:0] rem;
      logic [DVD_BITS-1:0]    dvd;
      logic [DVD_BITS-1:0]    quo;
   } div_state_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] rest;
      div_state_type          div;
      logic [OFFSET_BITS-1:0] idx;
      logic                   idx_use;
      logic [STRIDE_BITS-1:0] tmul;
      logic [PROD_BITS-1:0]   prod;
      logic [OFFSET_BITS-1:0] sum;
      logic                   ovf;
      logic                   err;
   } pipe_type;

endpackage

/* hw/rtl/sor_div_slice.sv */
// Combinational slice of a restoring divider: STEPS_PER_STAGE quotient bits.
// Depends on sor_pkg for widths and the divider state struct.

module sor_div_slice (
   input  sor_pkg::div_state_type              state_in,
   input  logic [sor_pkg::STRIDE_BITS-1:0]     divisor,
   output sor_pkg::div_state_type              state_out
);

   sor_pkg::div_state_type       st;
   logic [sor_pkg::STRIDE_BITS:0] trial;
   logic                         qbit;

   always_comb begin
      st    = state_in;
      trial = '0;
      qbit  = 1'b0;
      for (int j = 0; j < sor_pkg::STEPS_PER_STAGE; j++) begin
         // bring down the next dividend bit
         trial  = {st.rem, st.dvd[sor_pkg::DVD_BITS-1]};
         st.dvd = {st.dvd[sor_pkg::DVD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
            qbit  = 1'b1;
         end else begin
            qbit  = 1'b0;
         end
         st.rem = trial[sor_pkg::STRIDE_BITS-1:0];
         st.quo = {st.quo[sor_pkg::DVD_BITS-2:0], qbit};
      end
      state_out = st;
   end

endmodule

/* hw/rtl/strided_offset_remap_unit.sv */
// Top level of the strided offset remap unit: config registers and pipeline.
// Depends on sor_pkg and sor_div_slice.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_linear_offset
//   rsp       out        rsp_valid/rsp_stall  rsp_mapped_offset, rsp_overflow,
//                                             rsp_stride_error
//   csr       in         csr_write_en         csr_index, csr_wdata
//
// One item per cycle sustained while rsp_stall stays low; NUM_STAGES stages in all:
// an input stage, four division stages per dimension, and multiply and
// accumulate stages.
// Reset is synchronous: it empties the pipeline and loads the register defaults.
// Each stage holds while its successor is full and stalled; bubbles collapse,
// so req_stall rises only when every stage holds an item.

module strided_offset_remap_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sor_pkg::OFFSET_BITS-1:0]   req_linear_offset,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sor_pkg::OFFSET_BITS-1:0]   rsp_mapped_offset,
   output logic                              rsp_overflow,
   output logic                              rsp_stride_error,
   input  logic                              csr_write_en,
   input  logic [sor_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [sor_pkg::CFG_BITS-1:0]      csr_wdata
);

   localparam int NS = sor_pkg::NUM_STAGES;

   logic [sor_pkg::RANK_BITS-1:0] rank_ff;
   logic [sor_pkg::CFG_BITS-1:0]  src_strides_ff;
   logic [sor_pkg::CFG_BITS-1:0]  dst_strides_ff;
   logic                          red_en_ff;
   logic [sor_pkg::RDIM_BITS-1:0] red_dim_ff;

   logic [sor_pkg::RANK_BITS-1:0]   rank_used;
   logic [sor_pkg::USED_DIMS-1:0]   dim_used;
   logic [sor_pkg::USED_DIMS-1:0]   drop;
   logic [sor_pkg::STRIDE_BITS-1:0] src_s [sor_pkg::USED_DIMS];
   logic [sor_pkg::STRIDE_BITS-1:0] dst_s [sor_pkg::USED_DIMS];

   logic [NS-1:0]     valid_ff;
   logic [NS-1:0]     valid_in;
   logic [NS:0]       ready;
   sor_pkg::pipe_type stage_ff [NS];
   sor_pkg::pipe_type stage_in [NS];

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff        <= sor_pkg::RANK_BITS'(1);
         src_strides_ff <= sor_pkg::CFG_BITS'(1);
         dst_strides_ff <= sor_pkg::CFG_BITS'(1);
         red_en_ff      <= 1'b0;
         red_dim_ff     <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            sor_pkg::CSR_RANK:        rank_ff        <= csr_wdata[sor_pkg::RANK_BITS-1:0];
            sor_pkg::CSR_SRC_STRIDES: src_strides_ff <= csr_wdata;
            sor_pkg::CSR_DST_STRIDES: dst_strides_ff <= csr_wdata;
            sor_pkg::CSR_REDUCE_EN:   red_en_ff      <= csr_wdata[0];
            sor_pkg::CSR_REDUCE_DIM:  red_dim_ff     <= csr_wdata[sor_pkg::RDIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp rank into one..USED_DIMS and unpack per-dimension controls
   always_comb begin
      rank_used = rank_ff;
      if (rank_used == '0) begin
         rank_used = sor_pkg::RANK_BITS'(1);
      end
      if (rank_used > sor_pkg::RANK_BITS'(sor_pkg::USED_DIMS)) begin
         rank_used = sor_pkg::RANK_BITS'(sor_pkg::USED_DIMS);
      end
      for (int d = 0; d < sor_pkg::USED_DIMS; d++) begin
         dim_used[d] = sor_pkg::RANK_BITS'(d) < rank_used;
         drop[d]     = red_en_ff && (red_dim_ff == sor_pkg::RDIM_BITS'(d));
         src_s[d]    = src_strides_ff[(sor_pkg::PACKED_DIMS-1-d)*sor_pkg::STRIDE_BITS
                                      +: sor_pkg::STRIDE_BITS];
         dst_s[d]    = dst_strides_ff[(sor_pkg::PACKED_DIMS-1-d)*sor_pkg::STRIDE_BITS
                                      +: sor_pkg::STRIDE_BITS];
      end
   end

   // ---------------------------------------------------------------- handshake
   assign ready[NS]  = !rsp_stall;
   assign req_stall  = !ready[0];
   assign valid_in   = {valid_ff[NS-2:0], req_valid};

   for (genvar k = 0; k < NS; k++) begin : g_ready
      assign ready[k] = !valid_ff[k] || ready[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (ready[k] && valid_in[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      stage_in[0]      = '0;
      stage_in[0].rest = req_linear_offset;
   end

   for (genvar k = 1; k < NS; k++) begin : g_stage
      localparam int DIM      = (k - 1) / sor_pkg::DIV_STAGES;
      localparam int PH       = (k - 1) % sor_pkg::DIV_STAGES;
      localparam bit IS_DIV   = (k <= sor_pkg::LAST_DIV);
      localparam int DSEL     = IS_DIV ? DIM : 0;
      localparam bit IS_FIRST = IS_DIV && (PH == 0);
      localparam bit IS_LAST  = IS_DIV && (PH == sor_pkg::DIV_STAGES - 1);
      localparam bit IS_MUL   = (k >= 2) && (k - 1 <= sor_pkg::LAST_DIV) &&
                                ((k - 2) % sor_pkg::DIV_STAGES == sor_pkg::DIV_STAGES - 1);
      localparam bit IS_ACC   = (k >= 3) && (k - 2 <= sor_pkg::LAST_DIV) &&
                                ((k - 3) % sor_pkg::DIV_STAGES == sor_pkg::DIV_STAGES - 1);

      sor_pkg::div_state_type       div_out;
      logic [sor_pkg::OFFSET_BITS:0] acc_sum;
      logic                          acc_hi;

      if (IS_DIV) begin : g_div
         sor_pkg::div_state_type div_in;

         always_comb begin
            if (IS_FIRST) begin
               div_in     = '0;
               div_in.dvd = sor_pkg::DVD_BITS'(stage_ff[k-1].rest);
            end else begin
               div_in     = stage_ff[k-1].div;
            end
         end

         sor_div_slice u_div (
            .state_in  (div_in),
            .divisor   (src_s[DSEL]),
            .state_out (div_out)
         );
      end else begin : g_pass
         assign div_out = stage_ff[k-1].div;
      end

      always_comb begin
         acc_sum = {1'b0, stage_ff[k-1].sum} +
                   {1'b0, stage_ff[k-1].prod[sor_pkg::OFFSET_BITS-1:0]};
         acc_hi  = |stage_ff[k-1].prod[sor_pkg::PROD_BITS-1:sor_pkg::OFFSET_BITS];

         stage_in[k]     = stage_ff[k-1];
         stage_in[k].div = div_out;

         if (IS_LAST) begin
            if (!dim_used[DSEL]) begin
               stage_in[k].idx_use = 1'b0;
            end else if (src_s[DSEL] == '0) begin
               // zero stride: index 0, remainder left as it was
               stage_in[k].err     = 1'b1;
               stage_in[k].idx_use = 1'b0;
            end else begin
               stage_in[k].rest    = sor_pkg::OFFSET_BITS'(div_out.rem);
               stage_in[k].idx     = div_out.quo[sor_pkg::OFFSET_BITS-1:0];
               stage_in[k].idx_use = !drop[DSEL];
               stage_in[k].tmul    = dst_s[DSEL];
            end
         end

         if (IS_MUL) begin
            stage_in[k].prod = stage_ff[k-1].idx_use ?
                               sor_pkg::PROD_BITS'(stage_ff[k-1].idx) *
                               sor_pkg::PROD_BITS'(stage_ff[k-1].tmul) : '0;
         end

         // saturating accumulate: any carry or high product bit sticks as overflow
         if (IS_ACC) begin
            stage_in[k].sum = acc_sum[sor_pkg::OFFSET_BITS-1:0];
            stage_in[k].ovf = stage_ff[k-1].ovf || acc_hi || acc_sum[sor_pkg::OFFSET_BITS];
         end
      end
   end

   // ---------------------------------------------------------------- result
   assign rsp_valid         = valid_ff[NS-1];
   assign rsp_overflow      = stage_ff[NS-1].ovf;
   assign rsp_stride_error  = stage_ff[NS-1].err;
   assign rsp_mapped_offset = stage_ff[NS-1].ovf ? '1 : stage_ff[NS-1].sum;

   // ---------------------------------------------------------------- checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled while a pipeline stage is empty");

   a_err_reaches_output: assert property (@(posedge clock) disable iff (reset)
      ready[NS-1] && valid_ff[NS-2] && stage_ff[NS-2].err |=> rsp_stride_error)
      else $error("stride error lost in the last stage");

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      ready[NS-1] && valid_ff[NS-2] && stage_ff[NS-2].ovf
      |=> rsp_overflow && (rsp_mapped_offset == '1))
      else $error("overflow not carried to a saturated result");

endmodule

/* test/strided_offset_remap_unit_tb.sv */
// Self-checking testbench for strided_offset_remap_unit: random stalls on both channels,
// a scoreboard that predicts each remapped offset, and layout changes between phases.
// Depends on sor_pkg and the strided_offset_remap_unit RTL.
`timescale 1ns / 1ps

module strided_offset_remap_unit_tb;

   localparam int  LONG_HOLD    = 4 * sor_pkg::NUM_STAGES;
   localparam int  RANDOM_ITEMS = 1400;
   localparam logic [63:0] OFFSET_MAX = (64'd1 << sor_pkg::OFFSET_BITS) - 64'd1;

   typedef struct packed {
      logic [sor_pkg::OFFSET_BITS-1:0] mapped_offset;
      logic                            overflow;
      logic                            stride_error;
   } remap_result_type;

   typedef struct {
      bit [sor_pkg::RANK_BITS-1:0] rank;
      bit [sor_pkg::CFG_BITS-1:0]  src;
      bit [sor_pkg::CFG_BITS-1:0]  dst;
      bit                          ren;
      bit [sor_pkg::RDIM_BITS-1:0] rdim;
   } layout_cfg_type;

   class remap_scoreboard;
      bit [sor_pkg::RANK_BITS-1:0] rank;
      bit [sor_pkg::CFG_BITS-1:0]  src_strides;
      bit [sor_pkg::CFG_BITS-1:0]  dst_strides;
      bit                          reduce_en;
      bit [sor_pkg::RDIM_BITS-1:0] reduce_dim;
      remap_result_type            pending_q[$];
      int                          errors;

      function new();
         rank        = 3'd1;
         src_strides = 64'd1;
         dst_strides = 64'd1;
         reduce_en   = 1'b0;
         reduce_dim  = 2'd0;
         errors      = 0;
      endfunction

      function void set_reg(sor_pkg::csr_index_type idx, bit [sor_pkg::CFG_BITS-1:0] value);
         case (idx)
            sor_pkg::CSR_RANK:        rank        = value[sor_pkg::RANK_BITS-1:0];
            sor_pkg::CSR_SRC_STRIDES: src_strides = value;
            sor_pkg::CSR_DST_STRIDES: dst_strides = value;
            sor_pkg::CSR_REDUCE_EN:   reduce_en   = value[0];
            sor_pkg::CSR_REDUCE_DIM:  reduce_dim  = value[sor_pkg::RDIM_BITS-1:0];
            default: ;
         endcase
      endfunction

      function remap_result_type remap(bit [sor_pkg::OFFSET_BITS-1:0] offset);
         bit [63:0]        rest;
         bit [63:0]        sum;
         bit [63:0]        s;
         bit [63:0]        t;
         bit [63:0]        idx;
         bit               err;
         int               dims;
         remap_result_type res;
         rest = 64'(offset);
         sum  = 64'd0;
         err  = 1'b0;
         dims = int'(rank);
         if (dims == 0) dims = 1;
         if (dims > sor_pkg::USED_DIMS) dims = sor_pkg::USED_DIMS;
         for (int d = 0; d < dims; d++) begin
            s = 64'(src_strides[(sor_pkg::PACKED_DIMS-1-d)*sor_pkg::STRIDE_BITS
                                +: sor_pkg::STRIDE_BITS]);
            t = 64'(dst_strides[(sor_pkg::PACKED_DIMS-1-d)*sor_pkg::STRIDE_BITS
                                +: sor_pkg::STRIDE_BITS]);
            // a zero source stride leaves the remainder untouched
            if (s == 0) begin
               err = 1'b1;
            end else begin
               idx  = rest / s;
               rest = rest % s;
               if (!(reduce_en && d == int'(reduce_dim))) sum += idx * t;
            end
         end
         res.overflow      = (sum > OFFSET_MAX);
         res.mapped_offset = res.overflow ? OFFSET_MAX[sor_pkg::OFFSET_BITS-1:0]
                                          : sum[sor_pkg::OFFSET_BITS-1:0];
         res.stride_error  = err;
         return res;
      endfunction

      function void note_offset(bit [sor_pkg::OFFSET_BITS-1:0] offset);
         pending_q = {pending_q, remap(offset)};
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      function void report_field(string name, int unsigned exp_v, int unsigned act_v);
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      endfunction

      function void check_result(remap_result_type got);
         remap_result_type want;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual %0h", $time, got);
            return;
         end
         want = pending_q.pop_front();
         if (got.mapped_offset !== want.mapped_offset)
            report_field("mapped_offset", 32'(want.mapped_offset), 32'(got.mapped_offset));
         if (got.overflow !== want.overflow)
            report_field("overflow", 32'(want.overflow), 32'(got.overflow));
         if (got.stride_error !== want.stride_error)
            report_field("stride_error", 32'(want.stride_error), 32'(got.stride_error));
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [sor_pkg::OFFSET_BITS-1:0]  req_linear_offset;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [sor_pkg::OFFSET_BITS-1:0]  rsp_mapped_offset;
   logic                             rsp_overflow;
   logic                             rsp_stride_error;
   logic                             csr_write_en;
   logic [sor_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [sor_pkg::CFG_BITS-1:0]     csr_wdata;

   remap_scoreboard sb;
   bit              quiet_tx;
   bit              quiet_rx;
   bit              long_hold;
   bit [sor_pkg::OFFSET_BITS-1:0] stim_q[$];

   strided_offset_remap_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_linear_offset (req_linear_offset),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mapped_offset (rsp_mapped_offset),
      .rsp_overflow      (rsp_overflow),
      .rsp_stride_error  (rsp_stride_error),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result({rsp_mapped_offset, rsp_overflow, rsp_stride_error});
         if (req_valid && !req_stall)
            sb.note_offset(req_linear_offset);
      end
   end

   // result side: random back-pressure per item, one long hold on request
   initial begin
      int gap;
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (long_hold) begin
            gap       = LONG_HOLD;
            long_hold = 0;
         end else begin
            gap = quiet_rx ? 0 : $urandom_range(0, 6);
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic write_reg(sor_pkg::csr_index_type idx, bit [sor_pkg::CFG_BITS-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      sb.set_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic write_layout(layout_cfg_type cfg);
      write_reg(sor_pkg::CSR_RANK, sor_pkg::CFG_BITS'(cfg.rank));
      write_reg(sor_pkg::CSR_SRC_STRIDES, cfg.src);
      write_reg(sor_pkg::CSR_DST_STRIDES, cfg.dst);
      write_reg(sor_pkg::CSR_REDUCE_EN, sor_pkg::CFG_BITS'(cfg.ren));
      write_reg(sor_pkg::CSR_REDUCE_DIM, sor_pkg::CFG_BITS'(cfg.rdim));
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_offset(bit [sor_pkg::OFFSET_BITS-1:0] offset);
      int gap;
      gap = quiet_tx ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_linear_offset <= offset;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // hold the input quiet until every expected item is back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (sor_pkg::NUM_STAGES) @(negedge clock);
   endtask

   task automatic send_queued();
      while (stim_q.size() != 0) send_offset(stim_q.pop_front());
      drain();
   endtask

   task automatic make_random_layout(output layout_cfg_type cfg, output int span);
      int        kind;
      int        sz[4];
      bit [15:0] st[4];
      bit [15:0] dt[4];
      kind = $urandom_range(0, 9);
      for (int d = 0; d < 4; d++) sz[d] = $urandom_range(1, 16);
      st[3] = 16'd1;
      st[2] = 16'(sz[3]);
      st[1] = 16'(sz[3] * sz[2]);
      st[0] = 16'(sz[3] * sz[2] * sz[1]);
      span  = int'(st[0]) * sz[0];
      case ($urandom_range(0, 2))
         0: begin
            // transposed layout
            dt[0] = 16'd1;
            dt[1] = 16'(sz[0]);
            dt[2] = 16'(sz[0] * sz[1]);
            dt[3] = 16'(sz[0] * sz[1] * sz[2]);
         end
         1: for (int d = 0; d < 4; d++) dt[d] = 16'($urandom_range(0, 255));
         default: for (int d = 0; d < 4; d++) dt[d] = 16'($urandom_range(0, 65535));
      endcase
      if (kind == 6) st[$urandom_range(0, 3)] = 16'd0;
      cfg.src = {st[0], st[1], st[2], st[3]};
      cfg.dst = {dt[0], dt[1], dt[2], dt[3]};
      if (kind == 7 || kind == 8) begin
         cfg.src = {$urandom, $urandom};
         cfg.dst = {$urandom, $urandom};
         span    = 65536;
      end else if (kind == 9) begin
         cfg.src = $urandom_range(0, 1) ? '1 : '0;
         cfg.dst = '1;
         span    = 65536;
      end
      cfg.rank = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(1, 4));
      cfg.ren  = 1'($urandom_range(0, 1));
      cfg.rdim = 2'($urandom_range(0, 3));
   endtask

   initial begin
      layout_cfg_type cfg;
      int             span;
      int             count;
      int             random_done;
      int             phase_no;
      sb                = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_linear_offset = '0;
      csr_write_en      = 1'b0;
      csr_index         = sor_pkg::CSR_RANK;
      csr_wdata         = '0;
      quiet_tx          = 0;
      quiet_rx          = 0;
      long_hold         = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset layout: dimension 0 has a zero source stride
      stim_q = '{16'h0000, 16'hFFFF, 16'h5555};
      send_queued();

      // full rank, nibble reversal
      cfg = '{rank: 3'd4, src: 64'h1000_0100_0010_0001, dst: 64'h0001_0010_0100_1000,
              ren: 1'b0, rdim: 2'd0};
      write_layout(cfg);
      stim_q = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8000, 16'h0001, 16'hAAAA};
      send_queued();

      // zero rank acts as one; reduce dimension past the rank drops nothing
      cfg = '{rank: 3'd0, src: '1, dst: '1, ren: 1'b1, rdim: 2'd3};
      write_layout(cfg);
      stim_q = '{16'hFFFF, 16'hFFFE, 16'h0000};
      send_queued();

      // rank clamped, zero stride in dimension 1, saturating sum, outer dim reduced
      cfg = '{rank: 3'd7, src: {16'd100, 16'd0, 16'd10, 16'd1}, dst: '1,
              ren: 1'b1, rdim: 2'd0};
      write_layout(cfg);
      stim_q = '{16'hFFFF, 16'd99, 16'h7FFF, 16'd5};
      send_queued();

      // every source stride zero
      cfg = '{rank: 3'd4, src: '0, dst: '0, ren: 1'b0, rdim: 2'd2};
      write_layout(cfg);
      stim_q = '{16'h4321, 16'hFFFF};
      send_queued();

      // reduce a dimension inside the rank
      cfg = '{rank: 3'd3, src: 64'h0400_0040_0004_0001, dst: 64'h0001_0002_0004_0008,
              ren: 1'b1, rdim: 2'd1};
      write_layout(cfg);
      stim_q = '{16'h07FF, 16'h0445, 16'hFFFF};
      send_queued();

      random_done = 0;
      phase_no    = 0;
      while (random_done < RANDOM_ITEMS) begin
         make_random_layout(cfg, span);
         write_layout(cfg);
         quiet_tx = ($urandom_range(0, 3) == 0);
         quiet_rx = ($urandom_range(0, 3) == 0);
         // back up the pipe once: receiver holds off while the sender streams
         if (phase_no == 2) begin
            quiet_tx  = 1;
            long_hold = 1;
         end
         count = $urandom_range(60, 160);
         repeat (count) begin
            if ($urandom_range(0, 3) != 0)
               stim_q = {stim_q, 16'($urandom_range(0, span - 1))};
            else
               stim_q = {stim_q, 16'($urandom_range(0, 65535))};
         end
         send_queued();
         random_done += count;
         phase_no++;
      end

      if (sb.errors == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
